>>> src/dfr_pkg.sv
`default_nettype none

package dfr_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned CrcW     = 16;
  localparam int unsigned StatusW  = 3;
  localparam int unsigned PhaseW   = 2;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 16;

  localparam logic [ByteW-1:0]   DelimByte = 8'h7E;
  localparam logic [CrcW-1:0]    CrcPoly   = 16'h1021;
  localparam logic [ByteW-1:0]   CrcBytes  = 8'd2;

  localparam logic [ByteW-1:0]   PayloadLimitReset = 8'd255;
  localparam logic [CrcW-1:0]    CrcSeedReset      = 16'hFFFF;

  // Receiver phases
  localparam logic [PhaseW-1:0] PhHunt = 2'd0;
  localparam logic [PhaseW-1:0] PhLen  = 2'd1;
  localparam logic [PhaseW-1:0] PhData = 2'd2;
  localparam logic [PhaseW-1:0] PhCrc  = 2'd3;

  // Result status codes
  localparam logic [StatusW-1:0] StNone     = 3'd0;
  localparam logic [StatusW-1:0] StPayload  = 3'd1;
  localparam logic [StatusW-1:0] StGood     = 3'd2;
  localparam logic [StatusW-1:0] StCrcErr   = 3'd3;
  localparam logic [StatusW-1:0] StOverflow = 3'd4;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] RegPayloadLimit = 1'd0;
  localparam logic [CfgIdxW-1:0] RegCrcSeed      = 1'd1;

  // CRC-16-CCITT, MSB first, one byte
  function automatic logic [CrcW-1:0] crc_byte(input logic [CrcW-1:0] crc_in,
                                                input logic [ByteW-1:0] data);
    logic [CrcW-1:0] c;
    c = crc_in ^ {data, {(CrcW-ByteW){1'b0}}};
    for (int i = 0; i < ByteW; i++) begin
      if (c[CrcW-1]) begin
        c = {c[CrcW-2:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[CrcW-2:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

>>> src/dfr_if.sv
`default_nettype none

interface dfr_byte_if
  import dfr_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface dfr_status_if
  import dfr_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [StatusW-1:0] status;
  logic [ByteW-1:0]   payload_byte;
  logic [ByteW-1:0]   frame_length;

  modport source (output valid, output status, output payload_byte, output frame_length,
                  input ready);
  modport sink   (input valid, input status, input payload_byte, input frame_length,
                  output ready);
endinterface

`default_nettype wire

>>> src/delimited_frame_receiver_crc16_top.sv
// Channel   Dir  Payload                                   Meaning
// rx        in   in_byte[7:0]                              raw byte from the link
// st        out  status[2:0] payload_byte[7:0]             per-byte status, payload
//                frame_length[7:0]                         byte, length on frame good
// cfg       in   cfg_write cfg_index[0] cfg_data[15:0]     0 payload_limit, 1 crc_seed
//
// One byte per cycle sustained when the output is not stalled; each rx byte goes
// through the input register, then the result register, to st. The byte-wide CRC
// update and the phase step sit between the input and result registers.
// Reset (rst, synchronous) empties both registers and returns to hunting.
// A stalled result holds; rx stays ready while the input register can drain.

`default_nettype none

module delimited_frame_receiver_crc16_top
  import dfr_pkg::*;
(
  input  wire                 clk,
  input  wire                 rst,
  dfr_byte_if.sink            rx,
  dfr_status_if.source        st,
  input  wire                 cfg_write,
  input  wire [CfgIdxW-1:0]   cfg_index,
  input  wire [CfgDataW-1:0]  cfg_data
);

  // Configuration registers
  logic [ByteW-1:0] payload_limit;
  logic [CrcW-1:0]  crc_seed;

  always_ff @(posedge clk) begin
    if (rst) begin
      payload_limit <= PayloadLimitReset;
      crc_seed      <= CrcSeedReset;
    end else if (cfg_write) begin
      unique case (cfg_index)
        RegPayloadLimit: payload_limit <= cfg_data[ByteW-1:0];
        RegCrcSeed:      crc_seed      <= cfg_data[CrcW-1:0];
        default: ;
      endcase
    end
  end

  // Input register and result register handshake
  logic             in_valid;
  logic [ByteW-1:0] in_data;
  logic             out_free;
  logic             step;

  assign out_free = !st.valid || st.ready;
  assign step     = in_valid && out_free;
  assign rx.ready = !in_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (rx.ready) begin
      in_valid <= rx.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.valid && rx.ready) begin
      in_data <= rx.in_byte;
    end
  end

  // Receiver state
  logic [PhaseW-1:0] rx_phase, rx_phase_next;
  logic [ByteW-1:0]  previous_byte, previous_byte_next;
  logic [ByteW-1:0]  bytes_remaining, bytes_remaining_next;
  logic [ByteW-1:0]  bytes_stored, bytes_stored_next;
  logic [CrcW-1:0]   running_crc, running_crc_next;

  logic [StatusW-1:0] status_next;
  logic [ByteW-1:0]   payload_next;
  logic [ByteW-1:0]   length_next;
  logic [ByteW-1:0]   remaining_dec;
  logic [ByteW-1:0]   crc_expect;
  logic               to_hunt;

  assign remaining_dec = bytes_remaining - 8'd1;
  assign crc_expect    = remaining_dec[0] ? running_crc[CrcW-1:ByteW]
                                          : running_crc[ByteW-1:0];

  always_comb begin
    rx_phase_next        = rx_phase;
    previous_byte_next   = in_data;
    bytes_remaining_next = bytes_remaining;
    bytes_stored_next    = bytes_stored;
    running_crc_next     = running_crc;
    status_next          = StNone;
    payload_next         = '0;
    length_next          = '0;
    to_hunt              = 1'b0;

    if (in_data == DelimByte && previous_byte == DelimByte) begin
      // drop the stuffing byte and consume the pair
      previous_byte_next = '0;
    end else begin
      unique case (rx_phase)
        PhHunt: begin
          if (in_data == DelimByte) begin
            rx_phase_next     = PhLen;
            bytes_stored_next = '0;
            running_crc_next  = crc_seed;
          end
        end
        PhLen: begin
          if (in_data == '0) begin
            rx_phase_next        = PhCrc;
            bytes_remaining_next = CrcBytes;
          end else begin
            rx_phase_next        = PhData;
            bytes_remaining_next = in_data;
          end
        end
        PhData: begin
          if (bytes_stored >= payload_limit) begin
            status_next = StOverflow;
            to_hunt     = 1'b1;
          end else begin
            bytes_stored_next    = bytes_stored + 8'd1;
            running_crc_next     = crc_byte(running_crc, in_data);
            status_next          = StPayload;
            payload_next         = in_data;
            bytes_remaining_next = remaining_dec;
            if (remaining_dec == '0) begin
              rx_phase_next        = PhCrc;
              bytes_remaining_next = CrcBytes;
            end
          end
        end
        PhCrc: begin
          bytes_remaining_next = remaining_dec;
          if (crc_expect != in_data) begin
            status_next = StCrcErr;
            to_hunt     = 1'b1;
          end else if (remaining_dec == '0) begin
            status_next = StGood;
            length_next = bytes_stored;
            to_hunt     = 1'b1;
          end
        end
        default: ;
      endcase

      if (to_hunt) begin
        rx_phase_next        = PhHunt;
        previous_byte_next   = '0;
        bytes_remaining_next = '0;
        bytes_stored_next    = '0;
        running_crc_next     = crc_seed;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rx_phase        <= PhHunt;
      previous_byte   <= '0;
      bytes_remaining <= '0;
      bytes_stored    <= '0;
    end else if (step) begin
      rx_phase        <= rx_phase_next;
      previous_byte   <= previous_byte_next;
      bytes_remaining <= bytes_remaining_next;
      bytes_stored    <= bytes_stored_next;
    end
  end

  // Load the seed on reset, advance the CRC on each step
  always_ff @(posedge clk) begin
    if (rst) begin
      running_crc <= CrcSeedReset;
    end else if (step) begin
      running_crc <= running_crc_next;
    end
  end

  // Result register: advance on step, hold while stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      st.valid <= 1'b0;
    end else if (out_free) begin
      st.valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      st.status       <= status_next;
      st.payload_byte <= payload_next;
      st.frame_length <= length_next;
    end
  end

endmodule

`default_nettype wire

>>> src/dfr_checker.sv
`default_nettype none

module dfr_checker
  import dfr_pkg::*;
(
  input wire               clk,
  input wire               rst,
  input wire               rx_valid,
  input wire               rx_ready,
  input wire               st_valid,
  input wire               st_ready,
  input wire [StatusW-1:0] st_status,
  input wire [ByteW-1:0]   st_payload_byte,
  input wire [ByteW-1:0]   st_frame_length
);

  // Nothing comes out in the cycle after reset
  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> !st_valid)
    else $error("result valid straight after reset");

  // Input backpressure only when the result is stalled
  a_ready_cause: assert property (@(posedge clk) disable iff (rst)
    !rx_ready |-> (st_valid && !st_ready))
    else $error("input not ready without an output stall");

  // An accepted byte reaches the result register when the output drains
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (rx_valid && rx_ready) ##1 st_ready |=> st_valid)
    else $error("accepted byte did not reach the output");

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (st_valid && !st_ready) |=> (st_valid && $stable(st_status)
      && $stable(st_payload_byte) && $stable(st_frame_length)))
    else $error("stalled result changed");

endmodule

bind delimited_frame_receiver_crc16_top dfr_checker u_dfr_checker (
  .clk             (clk),
  .rst             (rst),
  .rx_valid        (rx.valid),
  .rx_ready        (rx.ready),
  .st_valid        (st.valid),
  .st_ready        (st.ready),
  .st_status       (st.status),
  .st_payload_byte (st.payload_byte),
  .st_frame_length (st.frame_length)
);

`default_nettype wire
